FILE: rtl/core/pal_pkg.sv
// Shared types and constants for the positional array list core.
// Field widths, request and status codes, controller/datapath handshake structs.
// No dependencies.
package pal_pkg;

  // Field widths of the request and result words
  localparam int ACTION_W = 2;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Request codes
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;   // latch the incoming request
    logic start;    // load scan address and move count
    logic scan;     // issue one memory read and step the address
    logic put;      // write the new value at the request position
    logic finish;   // load the result registers and commit the count
  } pal_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic err;         // request is refused
    logic scan_empty;  // no entries to move
    logic last;        // current scan read is the final one
    logic is_insert;   // latched request is an insert
  } pal_st_t;

endpackage

FILE: rtl/core/pal_in_if.sv
// Request channel: valid/ready handshake carrying one request word.
// Depends on pal_pkg.
interface pal_in_if;
  import pal_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic [POS_W-1:0]           position;
  logic signed [DATA_W-1:0]   value;

  modport source (output valid, output action, output position, output value, input ready);
  modport sink   (input valid, input action, input position, input value, output ready);
endinterface

FILE: rtl/core/pal_out_if.sv
// Result channel: valid/ready handshake carrying one result word.
// Depends on pal_pkg.
interface pal_out_if;
  import pal_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic signed [DATA_W-1:0]   data_out;
  logic [COUNT_W-1:0]         count;

  modport source (output valid, output status, output data_out, output count, input ready);
  modport sink   (input valid, input status, input data_out, input count, output ready);
endinterface

FILE: rtl/core/positional_array_list_core.sv
// Positional array list: a bounded ordered list of signed 32-bit words with
// insert, read and delete at a position. One request is handled at a time: a
// refused request skips the entry memory, a read fetches one word, a delete
// shifts the entries after the position down and an insert shifts the entries
// from the position up before it writes the new word. The entry memory has one
// read and one write port and moves one entry per cycle when later entries are
// shifted. The result sits in an output register; a new request is taken once
// the previous one has been loaded there, and a result still waiting on the
// output stalls the request in flight. Reset empties the list at once; the
// memory needs no clearing pass.
// Depends on pal_pkg, pal_in_if, pal_out_if, pal_ram, pal_ctrl and pal_dp.
module positional_array_list_core #(
  parameter int CAPACITY = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  pal_in_if.sink           in_ch,
  pal_out_if.source        out_ch
);
  import pal_pkg::*;

  pal_cmd_t cmd;
  pal_st_t  st;
  logic     in_ready;
  logic     out_valid;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  pal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  pal_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .st       (st),
    .action   (in_ch.action),
    .position (in_ch.position),
    .value    (in_ch.value),
    .status   (out_ch.status),
    .data_out (out_ch.data_out),
    .count    (out_ch.count)
  );

  // One request in flight: no second word right after acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request accepted while another is in flight");

  // Controller issues at most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.start, cmd.scan, cmd.put, cmd.finish}))
    else $error("conflicting datapath commands");

  // A finished request always shows up on the result port
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_ch.valid)
    else $error("result not presented after finish");

  // Full refusal only when the list holds CAPACITY entries
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == ST_FULL |-> out_ch.count == COUNT_W'(CAPACITY))
    else $error("full status with wrong count");

  // Empty refusal only on an empty list
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == ST_EMPTY |-> out_ch.count == '0)
    else $error("empty status with nonzero count");

endmodule

FILE: rtl/core/pal_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/pal_ctrl.sv
// Sequencing state machine for the list core: accept, check, move, put, respond.
// Depends on pal_pkg for the command and status structs.
module pal_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pal_pkg::pal_st_t  st,
  output pal_pkg::pal_cmd_t cmd
);
  import pal_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_SCAN   = 6'b000100,
    S_DRAIN  = 6'b001000,
    S_PUT    = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.accept = in_valid && (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.start = 1'b1;
        if (st.err)             state_nxt = S_FINISH;
        else if (st.scan_empty) state_nxt = S_PUT;
        else                    state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        // last read word is written back or captured this cycle
        state_nxt = st.is_insert ? S_PUT : S_FINISH;
      end
      S_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // wait for the result slot to free up
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.finish) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/core/pal_dp.sv
// Datapath of the list core: request registers, entry count, scan address,
// entry memory and result registers. Depends on pal_pkg and pal_ram.
module pal_dp #(
  parameter int CAPACITY = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pal_pkg::pal_cmd_t               cmd,
  output pal_pkg::pal_st_t                st,
  input  logic [pal_pkg::ACTION_W-1:0]    action,
  input  logic [pal_pkg::POS_W-1:0]       position,
  input  logic signed [pal_pkg::DATA_W-1:0] value,
  output logic [pal_pkg::STATUS_W-1:0]    status,
  output logic signed [pal_pkg::DATA_W-1:0] data_out,
  output logic [pal_pkg::COUNT_W-1:0]     count
);
  import pal_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  // Request registers
  logic [ACTION_W-1:0] act_r;
  logic [POS_W-1:0]    pos_r;
  logic [DATA_W-1:0]   val_r;

  // Control state
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic          pend_r;
  logic [AW-1:0] pend_addr_r;

  // Captured and result words
  logic [DATA_W-1:0]   got_r;
  logic [STATUS_W-1:0] status_r;
  logic [DATA_W-1:0]   data_r;
  logic [COUNT_W-1:0]  count_out_r;

  logic [CMPW-1:0]     c_ext, p_ext;
  logic [CW-1:0]       moves;
  logic [STATUS_W-1:0] code;
  logic                is_insert, is_read, is_delete;
  logic [AW-1:0]       pos_a;
  logic                pend_is_pos;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  assign is_insert = (act_r == ACT_INSERT);
  assign is_read   = (act_r == ACT_READ);
  assign is_delete = (act_r == ACT_DELETE);
  assign c_ext     = CMPW'(count_r);
  assign p_ext     = CMPW'(pos_r);
  assign pos_a     = AW'(pos_r);
  assign moves     = is_read ? CW'(1) : CW'(c_ext - p_ext);

  // Request check: full and empty are tested before the position
  always_comb begin
    unique case (act_r)
      ACT_INSERT: begin
        if (count_r == CW'(CAPACITY)) code = ST_FULL;
        else if (p_ext > c_ext)       code = ST_RANGE;
        else                          code = ST_DONE;
      end
      ACT_READ: begin
        code = (p_ext >= c_ext) ? ST_RANGE : ST_DONE;
      end
      ACT_DELETE: begin
        if (count_r == '0)       code = ST_EMPTY;
        else if (p_ext >= c_ext) code = ST_RANGE;
        else                     code = ST_DONE;
      end
      default: code = ST_RANGE;
    endcase
  end

  assign st.err        = (code != ST_DONE);
  assign st.scan_empty = (moves == '0);
  assign st.last       = (rem_r == CW'(1));
  assign st.is_insert  = is_insert;

  // Scan address and move count: insert walks down, read and delete walk up
  always_comb begin
    addr_nxt = addr_r;
    rem_nxt  = rem_r;
    if (cmd.start) begin
      addr_nxt = is_insert ? AW'(count_r - CW'(1)) : pos_a;
      rem_nxt  = moves;
    end else if (cmd.scan) begin
      addr_nxt = is_insert ? addr_r - AW'(1) : addr_r + AW'(1);
      rem_nxt  = rem_r - CW'(1);
    end
  end

  // Write port: put of the new word, or move of the word read last cycle
  assign pend_is_pos = (pend_addr_r == pos_a);
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr_r - AW'(1);
    ram_wdata = ram_rdata;
    if (cmd.put) begin
      ram_we    = 1'b1;
      ram_waddr = pos_a;
      ram_wdata = val_r;
    end else if (pend_r && is_insert) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_r + AW'(1);
    end else if (pend_r && is_delete && !pend_is_pos) begin
      ram_we    = 1'b1;
    end
  end

  // Count after the request
  always_comb begin
    count_nxt = count_r;
    if (code == ST_DONE && is_insert) count_nxt = count_r + CW'(1);
    if (code == ST_DONE && is_delete) count_nxt = count_r - CW'(1);
  end

  pal_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.scan),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      pend_r <= cmd.scan;
      if (cmd.finish) count_r <= count_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r <= action;
      pos_r <= position;
      val_r <= value;
    end
    addr_r <= addr_nxt;
    rem_r  <= rem_nxt;
    if (cmd.scan) pend_addr_r <= addr_r;
    // the word at the request position is the one returned
    if (pend_r && (is_read || (is_delete && pend_is_pos))) got_r <= ram_rdata;
    if (cmd.finish) begin
      status_r    <= code;
      data_r      <= (code == ST_DONE && (is_read || is_delete)) ? got_r : '0;
      count_out_r <= COUNT_W'(count_nxt);
    end
  end

  assign status   = status_r;
  assign data_out = data_r;
  assign count    = count_out_r;

endmodule

FILE: bench/positional_array_list_core_test.sv
// Self-checking bench for positional_array_list_core: random and directed list requests,
// each result checked against a shadow copy of the list kept in the bench.
// Depends on pal_pkg, pal_in_if, pal_out_if and the core itself.
`timescale 1ns / 100ps

module positional_array_list_core_test;
  import pal_pkg::*;

  localparam int CAPACITY    = 64;
  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_WORDS = 1350;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = CAPACITY + 10;
  localparam int CYCLE_LIMIT  = 600000;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  // Request word plus bench-side pacing flags
  typedef struct {
    logic [ACTION_W-1:0]      action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    bit                       drain;  // wait until every result is back
    bit                       hold;   // start a long receiver hold-off
    bit                       quiet;  // no more idling from here on
  } list_req_t;

  typedef struct {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] data_out;
    logic [COUNT_W-1:0]       count;
  } list_rsp_t;

  logic clk;
  logic rst_n;

  pal_in_if  req_if();
  pal_out_if rsp_if();

  positional_array_list_core #(.CAPACITY(CAPACITY)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (rsp_if)
  );

  // Shadow of the list contents
  logic signed [DATA_W-1:0] shadow_words [CAPACITY];
  int                       shadow_len;

  list_req_t pending_req_q[$];
  list_rsp_t expected_rsp_q[$];

  int  mismatch_count;
  int  words_taken;
  int  total_words;
  int  cycle_count;
  bit  req_taken;
  bit  quiet_mode;
  int  hold_seq;
  int  hold_seen;
  int  hold_left;
  int  send_gap;
  int  recv_gap;

  always #HALF_PERIOD clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Apply one request to the shadow list and return the result it should give
  function automatic list_rsp_t list_apply(input list_req_t rq);
    list_rsp_t rsp;
    int        pos;
    int        j;
    pos          = int'(rq.position);
    rsp.status   = ST_RANGE;
    rsp.data_out = '0;
    case (rq.action)
      ACT_INSERT: begin
        if (shadow_len >= CAPACITY) begin
          rsp.status = ST_FULL;
        end else if (pos <= shadow_len) begin
          for (j = shadow_len; j > pos; j--) shadow_words[j] = shadow_words[j-1];
          shadow_words[pos] = rq.value;
          shadow_len++;
          rsp.status = ST_DONE;
        end
      end
      ACT_READ: begin
        if (pos < shadow_len) begin
          rsp.status   = ST_DONE;
          rsp.data_out = shadow_words[pos];
        end
      end
      ACT_DELETE: begin
        if (shadow_len == 0) begin
          rsp.status = ST_EMPTY;
        end else if (pos < shadow_len) begin
          rsp.data_out = shadow_words[pos];
          for (j = pos; j + 1 < shadow_len; j++) shadow_words[j] = shadow_words[j+1];
          shadow_len--;
          rsp.status = ST_DONE;
        end
      end
      default: ;
    endcase
    rsp.count = COUNT_W'(shadow_len);
    return rsp;
  endfunction

  // Accepted request words feed the predictor; result words are checked in order
  always @(posedge clk) begin
    list_req_t rq;
    list_rsp_t want;
    req_taken <= rst_n && req_if.valid && req_if.ready;
    if (rst_n && req_if.valid && req_if.ready) begin
      rq.action   = req_if.action;
      rq.position = req_if.position;
      rq.value    = req_if.value;
      expected_rsp_q.push_back(list_apply(rq));
      words_taken++;
    end
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsp_q.size() == 0) begin
        report_mismatch($sformatf("result word with nothing expected: st=%0d data=%0d cnt=%0d",
                                  rsp_if.status, rsp_if.data_out, rsp_if.count));
      end else begin
        want = expected_rsp_q.pop_front();
        if (rsp_if.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", rsp_if.status, want.status));
        if (rsp_if.data_out !== want.data_out)
          report_mismatch($sformatf("data_out %0d, expected %0d",
                                    rsp_if.data_out, want.data_out));
        if (rsp_if.count !== want.count)
          report_mismatch($sformatf("count %0d, expected %0d", rsp_if.count, want.count));
      end
    end
  end

  // Request driver: holds a word until taken, then idles or offers the next one
  always @(negedge clk) begin
    list_req_t rq;
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else if (req_if.valid && !req_taken) begin
      // word still waiting for ready
    end else if (send_gap > 0) begin
      send_gap     <= send_gap - 1;
      req_if.valid <= 1'b0;
    end else if (!quiet_mode && $urandom_range(0, 6) == 0) begin
      send_gap     <= $urandom_range(1, 11) - 1;
      req_if.valid <= 1'b0;
    end else if (pending_req_q.size() != 0 &&
                 !(pending_req_q[0].drain && expected_rsp_q.size() != 0)) begin
      rq = pending_req_q.pop_front();
      req_if.action   <= rq.action;
      req_if.position <= rq.position;
      req_if.value    <= rq.value;
      req_if.valid    <= 1'b1;
      if (rq.hold) hold_seq <= hold_seq + 1;
      if (rq.quiet) quiet_mode <= 1'b1;
    end else begin
      req_if.valid <= 1'b0;
    end
  end

  // Result receiver: random stall bursts plus the occasional long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else if (hold_seen != hold_seq) begin
      hold_seen    <= hold_seq;
      hold_left    <= LONG_HOLD - 1;
      rsp_if.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap     <= recv_gap - 1;
      rsp_if.ready <= 1'b0;
    end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
      recv_gap     <= $urandom_range(1, 11) - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Append a request; gen_len tracks the entry count the request leaves behind
  task automatic queue_req(input logic [ACTION_W-1:0] action, input int position,
                           input logic signed [DATA_W-1:0] value, inout int gen_len,
                           input bit drain = 0, input bit hold = 0, input bit quiet = 0);
    list_req_t rq;
    rq.action   = action;
    rq.position = POS_W'(position);
    rq.value    = value;
    rq.drain    = drain;
    rq.hold     = hold;
    rq.quiet    = quiet;
    pending_req_q.push_back(rq);
    if (action == ACT_INSERT && gen_len < CAPACITY && int'(rq.position) <= gen_len)
      gen_len++;
    else if (action == ACT_DELETE && gen_len > 0 && int'(rq.position) < gen_len)
      gen_len--;
  endtask

  initial begin
    int                       gen_len;
    int                       i;
    int                       mode;
    int                       pick;
    int                       pos;
    logic [ACTION_W-1:0]      act;
    logic signed [DATA_W-1:0] val;
    clk            = 1'b0;
    rst_n          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.action   = ACT_INSERT;
    req_if.position = '0;
    req_if.value    = '0;
    rsp_if.ready    = 1'b0;
    mismatch_count = 0;
    words_taken    = 0;
    cycle_count    = 0;
    req_taken      = 1'b0;
    quiet_mode     = 1'b0;
    hold_seq       = 0;
    hold_seen      = 0;
    hold_left      = 0;
    send_gap       = 0;
    recv_gap       = 0;
    shadow_len     = 0;
    gen_len        = 0;

    // Directed: empty-list corners, extremes of value and position, middle ops
    queue_req(ACT_READ,   0,   32'sd0, gen_len);
    queue_req(ACT_DELETE, 0,   32'sd0, gen_len);
    queue_req(ACT_DELETE, 127, 32'sd0, gen_len);
    queue_req(ACT_UNUSED, 0,   32'sd0, gen_len);
    queue_req(ACT_INSERT, 1,   32'sd5, gen_len);
    queue_req(ACT_INSERT, 0,   32'sh7FFFFFFF, gen_len);
    queue_req(ACT_INSERT, 0,   32'sh80000000, gen_len);
    queue_req(ACT_INSERT, 2,   32'sd0, gen_len);
    queue_req(ACT_INSERT, 1,   32'shFFFFFFFF, gen_len);
    queue_req(ACT_INSERT, 5,   32'sd9, gen_len);
    for (i = 0; i < 4; i++) queue_req(ACT_READ, i, $urandom, gen_len);
    queue_req(ACT_READ,   4,   32'sd0, gen_len);
    queue_req(ACT_READ,   127, 32'sd0, gen_len);
    queue_req(ACT_DELETE, 4,   32'sd0, gen_len);
    queue_req(ACT_DELETE, 1,   $urandom, gen_len);
    queue_req(ACT_DELETE, 2,   32'sd0, gen_len);
    queue_req(ACT_UNUSED, 127, 32'shFFFFFFFF, gen_len);
    queue_req(ACT_READ,   1,   32'sd0, gen_len);
    queue_req(ACT_DELETE, 0,   32'sd0, gen_len);
    queue_req(ACT_DELETE, 0,   32'sd0, gen_len);
    queue_req(ACT_DELETE, 0,   32'sd0, gen_len);

    // Random: phases that grow the list to full, shrink it to empty, or mix
    for (i = 0; i < RANDOM_WORDS; i++) begin
      mode = (i / 120) % 3;
      pick = $urandom_range(0, 99);
      case (mode)
        0:       act = (pick < 75) ? ACT_INSERT : (pick < 88) ? ACT_READ :
                       (pick < 98) ? ACT_DELETE : ACT_UNUSED;
        1:       act = (pick < 15) ? ACT_INSERT : (pick < 30) ? ACT_READ :
                       (pick < 98) ? ACT_DELETE : ACT_UNUSED;
        default: act = (pick < 35) ? ACT_INSERT : (pick < 70) ? ACT_READ :
                       (pick < 98) ? ACT_DELETE : ACT_UNUSED;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        if (act == ACT_INSERT) pos = $urandom_range(0, gen_len);
        else pos = (gen_len > 0) ? $urandom_range(0, gen_len - 1) : 0;
      end else if (pick < 90) begin
        pos = gen_len;  // one past the end
      end else begin
        pos = $urandom_range(0, 127);
      end
      pick = $urandom_range(0, 19);
      case (pick)
        0:       val = 32'sh7FFFFFFF;
        1:       val = 32'sh80000000;
        2:       val = 32'shFFFFFFFF;
        3:       val = 32'sd0;
        default: val = $urandom;
      endcase
      queue_req(act, pos, val, gen_len, (i % 120) == 0, (i == 400) || (i == 1000),
                i == RANDOM_WORDS - 150);
    end
    total_words = pending_req_q.size();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (words_taken < total_words || expected_rsp_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_rsp_q.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", expected_rsp_q.size()));

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/pal_pkg.sv
rtl/core/pal_in_if.sv
rtl/core/pal_out_if.sv
rtl/core/pal_ram.sv
rtl/core/pal_ctrl.sv
rtl/core/pal_dp.sv
rtl/core/positional_array_list_core.sv
bench/positional_array_list_core_test.sv
